// ===== design/odi_pkg.sv =====
// Shared types, constants and the arctangent table for the wheel odometry integrator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
package odi_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int POS_FRAC_BITS = 24;
  localparam int STEP_W        = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int PROD_SHIFT    = 62 - POS_FRAC_BITS;
  localparam int PROD_W        = 98;
  localparam int CW            = 34;  // CORDIC datapath width
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] CORDIC_K = CW'(652032874);

  localparam logic [2:0] REG_MPC   = 3'd0;
  localparam logic [2:0] REG_TPC   = 3'd1;
  localparam logic [2:0] REG_SPEED = 3'd2;
  localparam logic [2:0] REG_TURN  = 3'd3;
  localparam logic [2:0] REG_VOLTS = 3'd4;

  typedef struct packed {
    logic [31:0]        foreaft_count;
    logic [31:0]        yaw_count;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic signed [15:0] yaw_rate_raw;
    logic [15:0]        battery_count;
    logic               pose_valid;
    logic               rates_valid;
    logic               battery_valid;
  } odi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
    logic [31:0]        voltage;
    logic               pose_updated;
    logic               rates_updated;
    logic               power_updated;
  } odi_out_t;

  typedef struct packed {
    logic [31:0] meters_per_count;
    logic [31:0] turns_per_count;
    logic [15:0] speed_scale;
    logic [15:0] turn_rate_scale;
    logic [15:0] volts_scale;
  } odi_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        pv;
    logic        rv;
    logic        bv;
    logic [31:0] dl;
    logic [31:0] dy;
    logic [31:0] speed;
    logic [31:0] turn_rate;
    logic [31:0] voltage;
  } odi_cmd_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  5'd31: r = 32'h00000000;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== design/odi_front.sv =====
// Front end: accepts sensor frames, forms count deltas and the rate outputs.
// Depends on odi_pkg; feeds odi_queue.
`timescale 1ns / 1ps
module odi_front import odi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  odi_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  odi_in_t  in_data,
  output logic     push,
  output odi_cmd_t push_data,
  input  logic     full
);

  logic [31:0] last_foreaft;
  logic [31:0] last_yaw;
  logic        first_frame;
  logic [31:0] held_speed, held_turn, held_volts;

  logic signed [16:0] rate_sum;
  logic signed [33:0] speed_prod;
  logic signed [32:0] turn_prod;
  logic signed [33:0] turn_neg;
  logic [31:0]        volt_prod;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    rate_sum   = 17'(in_data.left_rate) + 17'(in_data.right_rate);
    speed_prod = 34'(rate_sum) * 34'($signed({1'b0, cfg.speed_scale}));
    turn_prod  = 33'(in_data.yaw_rate_raw) * 33'($signed({1'b0, cfg.turn_rate_scale}));
    turn_neg   = -34'(turn_prod);
    volt_prod  = in_data.battery_count * cfg.volts_scale;

    push_data.pv = in_data.pose_valid;
    push_data.rv = in_data.rates_valid;
    push_data.bv = in_data.battery_valid;
    push_data.dl = first_frame ? 32'd0 : in_data.foreaft_count - last_foreaft;
    push_data.dy = first_frame ? 32'd0 : in_data.yaw_count - last_yaw;
    push_data.speed     = in_data.rates_valid ? speed_prod[32:1] : held_speed;
    push_data.turn_rate = in_data.rates_valid ? turn_neg[31:0] : held_turn;
    push_data.voltage   = in_data.battery_valid ? volt_prod : held_volts;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame  <= 1'b1;
      last_foreaft <= '0;
      last_yaw     <= '0;
      held_speed   <= '0;
      held_turn    <= '0;
      held_volts   <= '0;
    end else if (push) begin
      first_frame <= 1'b0;
      if (in_data.pose_valid) begin
        last_foreaft <= in_data.foreaft_count;
        last_yaw     <= in_data.yaw_count;
      end
      held_speed <= push_data.speed;
      held_turn  <= push_data.turn_rate;
      held_volts <= push_data.voltage;
    end
  end

endmodule

// ===== design/odi_queue.sv =====
// Short request queue between front and back.
// Depends on odi_pkg.
`timescale 1ns / 1ps
module odi_queue import odi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  odi_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output odi_cmd_t pop_data
);

  odi_cmd_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

// ===== design/odi_back.sv =====
// Back end: CORDIC of the held heading, position update and result register.
// Depends on odi_pkg; drains odi_queue.
`timescale 1ns / 1ps
module odi_back import odi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  odi_cfg_t cfg,
  input  logic     not_empty,
  input  odi_cmd_t pop_data,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output odi_out_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROT  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state;
  logic [STEP_W-1:0] step;
  logic [1:0]  mcnt;
  odi_cmd_t    cmd;
  logic [47:0] odom_x, odom_y;
  logic [31:0] odom_heading;

  logic signed [CW-1:0] cx, cy, cz;
  logic                 flip;
  logic signed [CW-1:0] kc, ks;
  logic [62:0] m;
  logic [63:0] prod_lo;

  logic [31:0] fold_a;
  logic        fold;
  logic signed [CW-1:0] xs, ys, at;
  logic [31:0] dmag;
  logic        dneg;
  logic signed [CW-1:0] ksel;
  logic [31:0] kmag, mul_a;
  logic [63:0] mul_p;
  logic [PROD_W-1:0] full_p;
  logic [47:0] r, r_signed;
  logic [31:0] heading_next;

  function automatic logic [31:0] pos_sat(input logic [47:0] p);
    logic signed [47:0] v;
    v = $signed(p);
    if (POS_FRAC_BITS >= 16) v = v >>> (POS_FRAC_BITS - 16);
    else                     v = v <<< (16 - POS_FRAC_BITS);
    if (v > 48'sh7FFFFFFF)                 return 32'h7FFFFFFF;
    else if (v < -48'sh80000000)           return 32'h80000000;
    else                                   return v[31:0];
  endfunction

  always_comb begin
    fold   = odom_heading[31] ^ odom_heading[30];
    fold_a = fold ? (odom_heading ^ 32'h80000000) : odom_heading;
    xs = cx >>> step;
    ys = cy >>> step;
    at = CW'(atan_turns(5'(step)));
    dneg = cmd.dl[31];
    dmag = dneg ? (32'd0 - cmd.dl) : cmd.dl;
    // rotation result, unfolded; stable through the multiply phase
    kc = flip ? -cx : cx;
    ks = flip ? -cy : cy;
    ksel = mcnt[1] ? ks : kc;
    kmag = ksel[CW-1] ? 32'(-ksel) : 32'(ksel);
    mul_a = mcnt[0] ? {1'b0, m[62:32]} : m[31:0];
    mul_p = mul_a * kmag;
    full_p = PROD_W'(prod_lo) + (PROD_W'(mul_p) << 32);
    r = full_p[PROD_SHIFT +: 48];
    r_signed = (dneg ^ ksel[CW-1]) ? (48'd0 - r) : r;
    heading_next = cmd.pv ? odom_heading + 32'(cmd.dy * cfg.turns_per_count)
                          : odom_heading;
  end

  assign pop = (state == S_IDLE) && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      odom_x       <= '0;
      odom_y       <= '0;
      odom_heading <= '0;
      step         <= '0;
      mcnt         <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (not_empty) begin
            cmd  <= pop_data;
            cx   <= CORDIC_K;
            cy   <= '0;
            cz   <= CW'($signed(fold_a));
            flip <= fold;
            step <= '0;
            mcnt <= '0;
            state <= pop_data.pv ? S_ROT : S_DONE;
          end
        end
        S_ROT: begin
          if (cz >= 0) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - at;
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + at;
          end
          m <= 63'(64'(dmag) * 64'(cfg.meters_per_count));
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_MUL;
          end
          step <= step + 1'b1;
        end
        S_MUL: begin
          mcnt <= mcnt + 1'b1;
          if (!mcnt[0]) prod_lo <= mul_p;
          else if (!mcnt[1]) odom_x <= odom_x + r_signed;
          else begin
            odom_y <= odom_y + r_signed;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            odom_heading <= heading_next;
            out_valid    <= 1'b1;
            out_data.pos_x   <= pos_sat(odom_x);
            out_data.pos_y   <= pos_sat(odom_y);
            out_data.heading <= heading_next[31:16];
            out_data.speed     <= cmd.speed;
            out_data.turn_rate <= cmd.turn_rate;
            out_data.voltage   <= cmd.voltage;
            out_data.pose_updated  <= cmd.pv;
            out_data.rates_updated <= cmd.rv;
            out_data.power_updated <= cmd.bv;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/wheel_odometry_integrator.sv =====
// Top level: configuration registers, front end, request queue and back end.
// Depends on odi_pkg, odi_front, odi_queue, odi_back.
`timescale 1ns / 1ps
// Dead-reckoning odometry for a differential-drive base. Each accepted sensor
// frame yields exactly one result. A frame with pose_valid set passes through the
// iterated CORDIC rotation and then the four partial products of the distance
// multiply through one shared 32x32 multiplier; a frame without pose data skips
// both and goes from idle straight to the result state. A
// two-entry queue lets the front accept frames while the back is busy, and the
// result register lets the back start the next frame while a result waits.
// Registers at byte addresses 0,4,8,12,16: meters_per_count, turns_per_count,
// speed_scale, turn_rate_scale, volts_scale; write only while idle.
module wheel_odometry_integrator import odi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  odi_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output odi_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  odi_cfg_t   cfg;
  logic [2:0] reg_idx;
  logic       push, full, pop, not_empty;
  odi_cmd_t   push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.meters_per_count <= 32'd129307;
      cfg.turns_per_count  <= 32'd38129;
      cfg.speed_scale      <= 16'd197;
      cfg.turn_rate_scale  <= 16'd147;
      cfg.volts_scale      <= 16'd16384;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MPC:   cfg.meters_per_count <= pwdata;
        REG_TPC:   cfg.turns_per_count  <= pwdata;
        REG_SPEED: cfg.speed_scale      <= pwdata[15:0];
        REG_TURN:  cfg.turn_rate_scale  <= pwdata[15:0];
        REG_VOLTS: cfg.volts_scale      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MPC:   prdata = cfg.meters_per_count;
      REG_TPC:   prdata = cfg.turns_per_count;
      REG_SPEED: prdata = {16'd0, cfg.speed_scale};
      REG_TURN:  prdata = {16'd0, cfg.turn_rate_scale};
      REG_VOLTS: prdata = {16'd0, cfg.volts_scale};
      default:   prdata = 32'd0;
    endcase
  end

  odi_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_ready, .in_data,
    .push, .push_data, .full
  );

  odi_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .not_empty, .pop_data
  );

  odi_back u_back (
    .clk, .rst, .cfg, .not_empty, .pop_data, .pop,
    .out_valid, .out_ready, .out_data
  );

endmodule

// ===== design/odi_checker.sv =====
// Port-level checks for the wheel odometry integrator, bound to the top level.
// Depends on odi_pkg.
`timescale 1ns / 1ps
module odi_checker import odi_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input odi_out_t out_data,
  input logic     pready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind wheel_odometry_integrator odi_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .out_data, .pready
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for wheel_odometry_integrator: directed and random sensor frames
// are checked against a built-in dead-reckoning predictor. Depends on odi_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import odi_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  odi_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  odi_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wheel_odometry_integrator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // predictor state
  logic [31:0] mpc_q = 32'd129307;
  logic [31:0] tpc_q = 32'd38129;
  logic [15:0] spd_scale_q = 16'd197;
  logic [15:0] turn_scale_q = 16'd147;
  logic [15:0] volt_scale_q = 16'd16384;
  logic signed [47:0] pose_x_q = '0;
  logic signed [47:0] pose_y_q = '0;
  logic [31:0] head_q = '0;
  logic [31:0] last_fa_q = '0;
  logic [31:0] last_yaw_q = '0;
  logic        fresh_q = 1'b1;
  logic [31:0] held_speed_q = '0;
  logic [31:0] held_turn_q = '0;
  logic [31:0] held_volts_q = '0;

  odi_in_t  frame_q[$];
  odi_out_t pose_expected[$];
  int       mismatches = 0;

  // idling controls
  int  send_idle_pct = 34;
  int  recv_idle_pct = 34;
  int  recv_holdoff = 0;
  bit  holdoff_go = 1'b0;
  bit  holdoff_done = 1'b0;

  function automatic logic [31:0] atan_table(input int i);
    logic [31:0] t[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                           32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                           32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                           32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    return t[i];
  endfunction

  function automatic void sincos_turns(input logic [31:0] ang,
                                       output logic signed [63:0] c,
                                       output logic signed [63:0] s);
    logic [31:0] a;
    logic        flip;
    logic signed [63:0] x, y, z, nx, xs, ys;
    a = ang;
    flip = 1'b0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a ^= 32'h80000000;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    z = {{32{a[31]}}, a};
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        nx = x - ys; y = y + xs; z = z - $signed({32'd0, atan_table(i)});
      end else begin
        nx = x + ys; y = y - xs; z = z + $signed({32'd0, atan_table(i)});
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // truncated toward zero: delta*mpc*k >> (62-24)
  function automatic logic [47:0] travel(input logic signed [31:0] delta,
                                         input logic [31:0] mpc,
                                         input logic signed [63:0] k);
    logic [127:0] mag;
    logic [63:0]  dm, km;
    logic         neg;
    neg = (delta < 0) != (k < 0);
    dm = delta < 0 ? 64'(-64'(delta)) : 64'(delta);
    km = k < 0 ? 64'(-k) : 64'(k);
    mag = (128'(dm) * 128'(mpc) * 128'(km)) >> 38;
    return neg ? 48'(-mag) : mag[47:0];
  endfunction

  function automatic logic [31:0] pos_word(input logic signed [47:0] p);
    logic signed [47:0] v;
    v = p >>> 8;
    if (v > 48'sd2147483647) return 32'h7FFFFFFF;
    if (v < -48'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic odi_out_t odometry_step(input odi_in_t f);
    odi_out_t r;
    logic [31:0] dl, dy;
    logic signed [63:0] c, s;
    logic signed [31:0] sp_sum;
    logic signed [63:0] sp, tr;
    if (f.pose_valid) begin
      dl = fresh_q ? 32'd0 : f.foreaft_count - last_fa_q;
      dy = fresh_q ? 32'd0 : f.yaw_count - last_yaw_q;
      last_fa_q = f.foreaft_count;
      last_yaw_q = f.yaw_count;
      sincos_turns(head_q, c, s);
      pose_x_q = pose_x_q + travel($signed(dl), mpc_q, c);
      pose_y_q = pose_y_q + travel($signed(dl), mpc_q, s);
      head_q = head_q + 32'(64'(dy) * 64'(tpc_q));
    end
    if (f.rates_valid) begin
      sp_sum = 32'(f.left_rate) + 32'(f.right_rate);
      sp = (64'(sp_sum) * $signed({48'd0, spd_scale_q})) >>> 1;
      tr = -64'(f.yaw_rate_raw) * $signed({48'd0, turn_scale_q});
      held_speed_q = sp[31:0];
      held_turn_q = tr[31:0];
    end
    if (f.battery_valid) held_volts_q = f.battery_count * volt_scale_q;
    fresh_q = 1'b0;
    r.pos_x = pos_word(pose_x_q);
    r.pos_y = pos_word(pose_y_q);
    r.heading = head_q[31:16];
    r.speed = held_speed_q;
    r.turn_rate = held_turn_q;
    r.voltage = held_volts_q;
    r.pose_updated = f.pose_valid;
    r.rates_updated = f.rates_valid;
    r.power_updated = f.battery_valid;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) pose_expected.push_back(odometry_step(in_data));
      if (frame_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= frame_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      recv_holdoff <= 0;
    end else if (holdoff_go && !holdoff_done) begin
      recv_holdoff <= 400;
      holdoff_done <= 1'b1;
    end else if (recv_holdoff > 0) begin
      recv_holdoff <= recv_holdoff - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pose_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          odi_out_t want;
          want = pose_expected.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      if (recv_holdoff > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MPC:   mpc_q = val;
      REG_TPC:   tpc_q = val;
      REG_SPEED: spd_scale_q = val[15:0];
      REG_TURN:  turn_scale_q = val[15:0];
      REG_VOLTS: volt_scale_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((frame_q.size() > 0 || in_valid || pose_expected.size() > 0) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic odi_in_t random_frame(input logic [31:0] fa, input logic [31:0] yw);
    odi_in_t f;
    f.foreaft_count = fa;
    f.yaw_count = yw;
    f.left_rate = 16'($urandom);
    f.right_rate = 16'($urandom);
    f.yaw_rate_raw = 16'($urandom);
    f.battery_count = 16'($urandom);
    f.pose_valid = $urandom_range(99) < 80;
    f.rates_valid = 1'($urandom_range(1));
    f.battery_valid = 1'($urandom_range(1));
    return f;
  endfunction

  task automatic random_phase(input int n, input int step_max);
    logic [31:0] fa, yw;
    fa = $urandom;
    yw = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        fa = $urandom; yw = $urandom;    // wild jump, exercises wrap
      end else begin
        fa = fa + 32'($signed($urandom_range(2 * step_max)) - step_max);
        yw = yw + 32'($signed($urandom_range(2 * step_max)) - step_max);
      end
      frame_q.push_back(random_frame(fa, yw));
    end
  endtask

  initial begin
    odi_in_t f;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // first frame without pose data, then extremes
    f = '0; f.rates_valid = 1'b1; f.left_rate = 16'sh7FFF; f.right_rate = 16'sh7FFF;
    f.yaw_rate_raw = 16'sh8000; f.foreaft_count = 32'hFFFFFFFF;
    frame_q.push_back(f);
    f = '0; f.pose_valid = 1'b1; f.foreaft_count = 32'h12345678; f.yaw_count = 32'hFFFFFFFF;
    f.battery_valid = 1'b1; f.battery_count = 16'hFFFF;
    frame_q.push_back(f);
    f.foreaft_count = 32'h12345678 + 32'd40000; f.yaw_count = 32'd20000;
    f.rates_valid = 1'b1; f.left_rate = 16'sh8000; f.right_rate = 16'sh8000;
    f.yaw_rate_raw = 16'sh7FFF;
    frame_q.push_back(f);
    f.foreaft_count = f.foreaft_count - 32'd90000; f.yaw_count = 32'hFFFF0000;
    frame_q.push_back(f);
    f.foreaft_count = f.foreaft_count + 32'h7FFFFFFF; frame_q.push_back(f);
    f.foreaft_count = f.foreaft_count + 32'h80000000; frame_q.push_back(f);
    f.pose_valid = 1'b0; f.foreaft_count = '0; frame_q.push_back(f);
    f.pose_valid = 1'b1; f.rates_valid = 1'b0; f.battery_valid = 1'b0; frame_q.push_back(f);
    drain();

    // extremes of the scales
    apb_write(REG_MPC, 32'hFFFFFFFF); apb_write(REG_TPC, 32'hFFFFFFFF);
    apb_write(REG_SPEED, 32'hFFFF); apb_write(REG_TURN, 32'hFFFF);
    apb_write(REG_VOLTS, 32'hFFFF);
    send_idle_pct = 0; recv_idle_pct = 0;   // no idling in this stretch
    random_phase(300, 4000);
    drain();

    apb_write(REG_MPC, 32'd0); apb_write(REG_TPC, 32'd0);
    apb_write(REG_SPEED, 32'd0); apb_write(REG_TURN, 32'd0); apb_write(REG_VOLTS, 32'd0);
    send_idle_pct = 34; recv_idle_pct = 34;
    random_phase(100, 1000);
    drain();

    apb_write(REG_MPC, 32'd129307); apb_write(REG_TPC, 32'h01000000);
    apb_write(REG_SPEED, 32'd197); apb_write(REG_TURN, 32'd147);
    apb_write(REG_VOLTS, 32'd16384);
    // long receiver hold-off fills the queue and stalls input
    @(posedge clk);
    holdoff_go = 1'b1;
    random_phase(700, 20000);
    drain();

    // random register values, then random frames with large count steps
    apb_write(REG_MPC, $urandom); apb_write(REG_TPC, $urandom);
    apb_write(REG_SPEED, $urandom); apb_write(REG_TURN, $urandom);
    apb_write(REG_VOLTS, $urandom);
    random_phase(680, 200000);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/odi_pkg.sv
design/odi_front.sv
design/odi_queue.sv
design/odi_back.sv
design/wheel_odometry_integrator.sv
design/odi_checker.sv
tb/sv/tb_top.sv
